// ===== rtl/core/cdre_pkg.sv =====
package cdre_pkg;

    // Default number of chroma cluster centres.
    localparam int CLUSTERS_DEF = 3;

    // Configuration port geometry: two registers per cluster centre.
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int CFG_PER_CLUSTER = 2;
    localparam int CFG_CB_OFS      = 0;
    localparam int CFG_CR_OFS      = 1;
    localparam logic [CFG_DATA_W-1:0] CENTER_RESET = 8'd128;

    // Byte stream constants.
    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 6;
    localparam int MAX_RESULTS = 3;
    localparam logic [RUN_W-1:0]  RUN_MAX = 6'd63;
    localparam logic [BYTE_W-1:0] RUN_TAG = 8'hC0;

    // Saturation limits of a chroma difference, and the bias of its code.
    localparam logic signed [8:0] DELTA_MAX  = 9'sd3;
    localparam logic signed [8:0] DELTA_MIN  = -9'sd4;
    localparam logic [2:0]        DELTA_BIAS = 3'd3;

    // One classified pixel.
    typedef struct packed {
        logic        background;
        logic [1:0]  cluster;
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
        logic        end_of_image;
    } t_pixel;

    // Bytes caused by one pixel; byte 0 goes out first.
    typedef struct packed {
        logic [1:0]                          count;
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    } t_result;

    // Saturated chroma difference, coded as bias minus difference.
    function automatic logic [2:0] delta_code(input logic [7:0] pix,
                                              input logic [7:0] centre);
        logic signed [8:0] d;
        d = $signed({1'b0, pix}) - $signed({1'b0, centre});
        if (d > DELTA_MAX) begin
            d = DELTA_MAX;
        end else if (d < DELTA_MIN) begin
            d = DELTA_MIN;
        end
        return DELTA_BIAS - d[2:0];
    endfunction

endpackage

// ===== rtl/core/cdre_pix_if.sv =====
interface cdre_pix_if;
    logic       valid;
    logic       ready;
    logic       background;
    logic [1:0] cluster;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       end_of_image;

    modport source (
        output valid, background, cluster, luma, chroma_blue, chroma_red, end_of_image,
        input  ready
    );
    modport sink (
        input  valid, background, cluster, luma, chroma_blue, chroma_red, end_of_image,
        output ready
    );
endinterface

// ===== rtl/core/cdre_byte_if.sv =====
interface cdre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;

    modport source (
        output valid, out_byte, last_of_item,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_item,
        output ready
    );
endinterface

// ===== rtl/core/cdre_cfg_regs.sv =====
module cdre_cfg_regs #(
    parameter int CLUSTERS = cdre_pkg::CLUSTERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cdre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [cdre_pkg::CFG_DATA_W-1:0] o_center_cb [CLUSTERS],
    output logic [cdre_pkg::CFG_DATA_W-1:0] o_center_cr [CLUSTERS]
);
    import cdre_pkg::*;

    logic [CFG_DATA_W-1:0] r_center_cb [CLUSTERS];
    logic [CFG_DATA_W-1:0] r_center_cr [CLUSTERS];

    // Register file: each centre has a Cb and a Cr register; other indexes are dropped.
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CLUSTERS; c++) begin
            if (!i_rst_n) begin
                r_center_cb[c] <= CENTER_RESET;
                r_center_cr[c] <= CENTER_RESET;
            end else if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_PER_CLUSTER * c + CFG_CB_OFS)) begin
                    r_center_cb[c] <= i_cfg_data;
                end
                if (i_cfg_index == CFG_IDX_W'(CFG_PER_CLUSTER * c + CFG_CR_OFS)) begin
                    r_center_cr[c] <= i_cfg_data;
                end
            end
        end
    end

    assign o_center_cb = r_center_cb;
    assign o_center_cr = r_center_cr;

endmodule

// ===== rtl/core/cdre_in_reg.sv =====
module cdre_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdre_pix_if.sink          i_pix,
    input  logic              i_take,
    output logic              o_valid,
    output cdre_pkg::t_pixel  o_pixel
);
    import cdre_pkg::*;

    logic   r_valid;
    t_pixel r_pixel;

    // The register is free when empty or when its pixel moves on this cycle.
    assign i_pix.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    // Payload is captured on every transfer.
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_pixel.background   <= i_pix.background;
            r_pixel.cluster      <= i_pix.cluster;
            r_pixel.luma         <= i_pix.luma;
            r_pixel.chroma_blue  <= i_pix.chroma_blue;
            r_pixel.chroma_red   <= i_pix.chroma_red;
            r_pixel.end_of_image <= i_pix.end_of_image;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

// ===== rtl/core/cdre_encode.sv =====
module cdre_encode #(
    parameter int CLUSTERS = cdre_pkg::CLUSTERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  cdre_pkg::t_pixel                i_pixel,
    input  logic [cdre_pkg::CFG_DATA_W-1:0] i_center_cb [CLUSTERS],
    input  logic [cdre_pkg::CFG_DATA_W-1:0] i_center_cr [CLUSTERS],
    output cdre_pkg::t_result               o_result
);
    import cdre_pkg::*;

    localparam int CW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;

    logic [RUN_W-1:0]  r_run;
    logic [RUN_W-1:0]  n_run;
    logic [RUN_W-1:0]  run_inc;
    logic [1:0]        cl_sat;
    logic [CW-1:0]     cl_sel;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] run_byte;
    logic [BYTE_W-1:0] inc_byte;
    t_result           result;

    // An index beyond the last centre is clamped to the last centre.
    assign cl_sat = (i_pixel.cluster >= 2'(CLUSTERS)) ? 2'(CLUSTERS - 1) : i_pixel.cluster;
    assign cl_sel = cl_sat[CW-1:0];

    assign first_byte = {cl_sat,
                         delta_code(i_pixel.chroma_blue, i_center_cb[cl_sel]),
                         delta_code(i_pixel.chroma_red,  i_center_cr[cl_sel])};
    assign run_inc    = r_run + 6'd1;
    assign run_byte   = RUN_TAG | {2'b00, r_run};
    assign inc_byte   = RUN_TAG | {2'b00, run_inc};

    // Byte list and next run count for the pixel in the input register.
    always_comb begin
        n_run          = r_run;
        result.count   = 2'd0;
        result.bytes   = '0;
        if (i_pixel.background) begin
            if (run_inc == RUN_MAX) begin
                result.bytes[0] = RUN_TAG | {2'b00, RUN_MAX};
                result.count    = 2'd1;
                n_run           = '0;
            end else if (i_pixel.end_of_image) begin
                result.bytes[0] = inc_byte;
                result.count    = 2'd1;
                n_run           = '0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            n_run = '0;
            if (r_run != '0) begin
                result.bytes[0] = run_byte;
                result.bytes[1] = first_byte;
                result.bytes[2] = i_pixel.luma;
                result.count    = 2'd3;
            end else begin
                result.bytes[0] = first_byte;
                result.bytes[1] = i_pixel.luma;
                result.count    = 2'd2;
            end
        end
    end

    // The run count advances once per pixel handed to the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_take) begin
            r_run <= n_run;
        end
    end

    assign o_result = result;

endmodule

// ===== rtl/core/cdre_out_buf.sv =====
module cdre_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cdre_pkg::t_result  i_result,
    output logic               o_take,
    cdre_byte_if.source        o_byte
);
    import cdre_pkg::*;

    logic [1:0]                          r_count;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] r_bytes;
    logic                                xfer;

    assign xfer = (r_count != 2'd0) && o_byte.ready;

    // A new pixel's bytes load once the last pending byte is gone or leaves now.
    assign o_take = i_valid && ((r_count == 2'd0) || ((r_count == 2'd1) && o_byte.ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (o_take) begin
            r_count <= i_result.count;
        end else if (xfer) begin
            r_count <= r_count - 2'd1;
        end
    end

    // Bytes shift toward slot 0 as each one is transferred.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bytes <= i_result.bytes;
        end else if (xfer) begin
            r_bytes <= {{BYTE_W{1'b0}}, r_bytes[MAX_RESULTS-1:1]};
        end
    end

    assign o_byte.valid        = (r_count != 2'd0);
    assign o_byte.out_byte     = r_bytes[0];
    assign o_byte.last_of_item = (r_count == 2'd1);

endmodule

// ===== rtl/core/cluster_delta_run_encoder.sv =====
// Cluster delta run encoder.
// Pixels arrive on i_pix (valid/ready); the compressed stream leaves on o_byte,
// one byte per transfer, with last_of_item set on the final byte a pixel causes.
// Background pixels are counted and sent as one run byte when the count reaches
// 63, before a cluster pixel, or at end of image. A cluster pixel sends an index
// and chroma delta byte followed by its luma byte.
// Cluster centres are written through i_cfg_we/i_cfg_index/i_cfg_data; index 2c
// holds Cb and 2c+1 holds Cr of centre c. The user must write them only while the
// block is idle; the block itself does not enforce this. A pixel passes through the
// input register and then the output register before its first byte is valid.
// Throughput: one pixel per cycle while the output register is empty and pixels
// cause no byte; a pixel that causes bytes holds the output register until its
// last byte leaves, and the next pixel's bytes load as that last byte goes. The
// output register and its byte count set this pace.
// Reset clears the run count, empties both stages and sets every centre to 128.
// When the receiver stalls, the current byte holds, the input register fills and
// then ready drops; nothing is lost.
module cluster_delta_run_encoder #(
    parameter int CLUSTERS = cdre_pkg::CLUSTERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cdre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cdre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cdre_pix_if.sink                        i_pix,
    cdre_byte_if.source                     o_byte
);
    import cdre_pkg::*;

    logic [CFG_DATA_W-1:0] center_cb [CLUSTERS];
    logic [CFG_DATA_W-1:0] center_cr [CLUSTERS];
    logic                  pix_valid;
    t_pixel                pix;
    logic                  take;
    t_result               result;

    cdre_cfg_regs #(
        .CLUSTERS (CLUSTERS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_center_cb (center_cb),
        .o_center_cr (center_cr)
    );

    cdre_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_take  (take),
        .o_valid (pix_valid),
        .o_pixel (pix)
    );

    cdre_encode #(
        .CLUSTERS (CLUSTERS)
    ) u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_pixel     (pix),
        .i_center_cb (center_cb),
        .i_center_cr (center_cr),
        .o_result    (result)
    );

    cdre_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pix_valid),
        .i_result (result),
        .o_take   (take),
        .o_byte   (o_byte)
    );

endmodule

// ===== sim/cluster_delta_run_encoder_test.sv =====
module cluster_delta_run_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdre_pkg::*;

    // Register map of the configuration port; the two spare indexes are not decoded.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CB_ZERO,
        REG_CR_ZERO,
        REG_CB_ONE,
        REG_CR_ONE,
        REG_CB_TWO,
        REG_CR_TWO,
        REG_SPARE_A,
        REG_SPARE_B
    } t_cfg_reg;

    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 30;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_coded_byte;

    // Predicts the byte stream and checks each output transfer against it.
    class t_run_delta_scoreboard;
        logic [7:0]  centre[6];
        logic [5:0]  run_len;
        t_coded_byte expected_bytes[$];
        int          failures;

        function new();
            foreach (centre[i]) begin
                centre[i] = CENTER_RESET;
            end
            run_len  = '0;
            failures = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [7:0] val);
            if (idx <= REG_CR_TWO) begin
                centre[idx] = val;
            end
        endfunction

        // Saturated chroma difference, coded as three minus the difference.
        function logic [2:0] chroma_code(logic [7:0] pix, logic [7:0] ctr);
            int d;
            d = int'(pix) - int'(ctr);
            if (d > int'(DELTA_MAX)) begin
                d = int'(DELTA_MAX);
            end else if (d < int'(DELTA_MIN)) begin
                d = int'(DELTA_MIN);
            end
            return 3'(int'(DELTA_BIAS) - d);
        endfunction

        // Works out the bytes that one accepted pixel causes.
        function void note_pixel(t_pixel p);
            logic [7:0]  burst[$];
            logic [1:0]  idx;
            logic [7:0]  first_code;
            t_coded_byte cb;
            if (p.background) begin
                run_len = run_len + 6'd1;
                if (run_len == RUN_MAX) begin
                    burst = {burst, RUN_TAG | 8'(RUN_MAX)};
                    run_len = '0;
                end
            end else begin
                idx = (p.cluster >= CLUSTERS_DEF) ? 2'(CLUSTERS_DEF - 1) : p.cluster;
                if (run_len != 0) begin
                    burst = {burst, RUN_TAG | 8'(run_len)};
                    run_len = '0;
                end
                first_code = {idx,
                    chroma_code(p.chroma_blue, centre[idx * CFG_PER_CLUSTER + CFG_CB_OFS]),
                    chroma_code(p.chroma_red, centre[idx * CFG_PER_CLUSTER + CFG_CR_OFS])};
                burst = {burst, first_code};
                burst = {burst, p.luma};
            end
            if (p.end_of_image && run_len != 0) begin
                burst = {burst, RUN_TAG | 8'(run_len)};
                run_len = '0;
            end
            foreach (burst[i]) begin
                cb.value = burst[i];
                cb.last  = (i == burst.size() - 1);
                expected_bytes = {expected_bytes, cb};
            end
        endfunction

        task report_mismatch(string msg);
            failures++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_byte(logic [7:0] value, logic last);
            t_coded_byte want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h arrived with nothing expected", value));
            end else begin
                want = expected_bytes.pop_front();
                if (value !== want.value) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h", value, want.value));
                end
                if (last !== want.last) begin
                    report_mismatch($sformatf("last_of_item %0b, expected %0b on byte %02h",
                                              last, want.last, want.value));
                end
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cdre_pix_if  pix_bus ();
    cdre_byte_if byte_bus ();

    cluster_delta_run_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_bus),
        .o_byte      (byte_bus)
    );

    t_run_delta_scoreboard stream_book = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks every output transfer and decides ready for the next edge.
    initial begin
        int hold_left;
        hold_left = 0;
        byte_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && byte_bus.valid && byte_bus.ready) begin
                stream_book.check_byte(byte_bus.out_byte, byte_bus.last_of_item);
            end
            if (hold_left > 0) begin
                hold_left--;
                byte_bus.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                byte_bus.ready <= 1'b0;
            end else begin
                byte_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((pix_bus.valid && pix_bus.ready) || (byte_bus.valid && byte_bus.ready)
                    || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("cluster_delta_run_encoder_test failed");
                $finish;
            end
        end
    end

    function automatic t_pixel make_pixel(logic bg, logic [1:0] cl, logic [7:0] y,
                                          logic [7:0] cb, logic [7:0] cr, logic eoi);
        t_pixel p;
        p.background   = bg;
        p.cluster      = cl;
        p.luma         = y;
        p.chroma_blue  = cb;
        p.chroma_red   = cr;
        p.end_of_image = eoi;
        return p;
    endfunction

    // Chroma close to a centre most of the time, so that every delta code shows up.
    function automatic logic [7:0] near_centre(logic [7:0] ctr);
        if ($urandom_range(3) == 0) begin
            return 8'($urandom);
        end
        return ctr + 8'($urandom_range(12)) - 8'd6;
    endfunction

    function automatic t_pixel random_cluster_pixel();
        logic [1:0] cl;
        int         sel;
        cl  = 2'($urandom_range(3));
        sel = (cl >= CLUSTERS_DEF) ? CLUSTERS_DEF - 1 : cl;
        return make_pixel(1'b0, cl, 8'($urandom),
                          near_centre(stream_book.centre[sel * CFG_PER_CLUSTER + CFG_CB_OFS]),
                          near_centre(stream_book.centre[sel * CFG_PER_CLUSTER + CFG_CR_OFS]),
                          1'b0);
    endfunction

    // One pixel transfer, preceded by random idle cycles on the sender side.
    task automatic send_pixel(t_pixel p);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid        <= 1'b1;
        pix_bus.background   <= p.background;
        pix_bus.cluster      <= p.cluster;
        pix_bus.luma         <= p.luma;
        pix_bus.chroma_blue  <= p.chroma_blue;
        pix_bus.chroma_red   <= p.chroma_red;
        pix_bus.end_of_image <= p.end_of_image;
        do begin
            @(posedge i_clk);
        end while (!pix_bus.ready);
        stream_book.note_pixel(p);
    endtask

    // A whole image: runs of background and cluster pixels, or now and then plain noise.
    task automatic send_image(output int sent);
        t_pixel seq[$];
        int     segs;
        int     bg_len;
        int     cl_n;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(8, 1)) begin
                seq = {seq, make_pixel(1'($urandom), 2'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom), 1'($urandom))};
            end
        end else begin
            segs = $urandom_range(5, 1);
            repeat (segs) begin
                bg_len = ($urandom_range(9) == 0) ? $urandom_range(70, 55) : $urandom_range(6);
                cl_n   = $urandom_range(3);
                repeat (bg_len) begin
                    seq = {seq, make_pixel(1'b1, 2'($urandom), 8'($urandom),
                                           8'($urandom), 8'($urandom), 1'b0)};
                end
                repeat (cl_n) begin
                    seq = {seq, random_cluster_pixel()};
                end
            end
            if (seq.size() == 0) begin
                seq = {seq, make_pixel(1'b1, 2'd0, 8'd0, 8'd0, 8'd0, 1'b0)};
            end
            seq[seq.size() - 1].end_of_image = 1'b1;
        end
        foreach (seq[i]) begin
            send_pixel(seq[i]);
            if (tx_idle_pct == 0 && rx_idle_pct == 0 && i == 2 && !hold_request) begin
                hold_request = 1'b1;
            end
        end
        sent = seq.size();
    endtask

    // Wait until every expected byte has left and the pipeline has emptied.
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (stream_book.expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        stream_book.write_reg(idx, val);
    endtask

    // All six centres from one rule, plus writes to the undecoded indexes.
    task automatic load_centres(int phase);
        t_cfg_reg   r;
        logic [7:0] val;
        r = REG_CB_ZERO;
        repeat (6) begin
            case (phase)
                0: val = 8'h00;
                1: val = 8'hFF;
                default: val = 8'($urandom);
            endcase
            write_reg(r, val);
            r = r.next();
        end
        write_reg(REG_SPARE_A, 8'($urandom));
        write_reg(REG_SPARE_B, 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Main sequence: reset, directed pixels, then four phases of random images.
    initial begin
        t_pixel directed[$];
        int     phase_sent;
        int     sent;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= REG_CB_ZERO;
        i_cfg_data           <= '0;
        pix_bus.valid        <= 1'b0;
        pix_bus.background   <= 1'b0;
        pix_bus.cluster      <= '0;
        pix_bus.luma         <= '0;
        pix_bus.chroma_blue  <= '0;
        pix_bus.chroma_red   <= '0;
        pix_bus.end_of_image <= 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels against the reset centres of 128.
        directed = {directed, make_pixel(1'b0, 2'd0, 8'h00, 8'd128, 8'd128, 1'b0)};
        directed = {directed, make_pixel(1'b0, 2'd1, 8'hFF, 8'd255, 8'd0, 1'b0)};
        directed = {directed, make_pixel(1'b0, 2'd2, 8'h55, 8'd131, 8'd124, 1'b0)};
        directed = {directed, make_pixel(1'b0, 2'd2, 8'hAA, 8'd132, 8'd123, 1'b0)};
        // Index three saturates to the last cluster.
        directed = {directed, make_pixel(1'b0, 2'd3, 8'h01, 8'd0, 8'd255, 1'b0)};
        // A pending run goes out ahead of a cluster pixel.
        directed = {directed, make_pixel(1'b1, 2'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0)};
        directed = {directed, make_pixel(1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0)};
        directed = {directed, make_pixel(1'b1, 2'd1, 8'h12, 8'h34, 8'h56, 1'b0)};
        directed = {directed, make_pixel(1'b0, 2'd0, 8'h80, 8'd127, 8'd129, 1'b0)};
        // End of image flushes the run.
        directed = {directed, make_pixel(1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0)};
        directed = {directed, make_pixel(1'b1, 2'd2, 8'h00, 8'h00, 8'h00, 1'b1)};
        // End of image on a cluster pixel with no run pending.
        directed = {directed, make_pixel(1'b0, 2'd1, 8'h7F, 8'd128, 8'd128, 1'b1)};
        // Run, then a cluster pixel that also ends the image.
        directed = {directed, make_pixel(1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0)};
        directed = {directed, make_pixel(1'b0, 2'd2, 8'hC3, 8'd100, 8'd200, 1'b1)};
        // A single background pixel that ends the image.
        directed = {directed, make_pixel(1'b1, 2'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1)};
        directed = {directed, make_pixel(1'b0, 2'd0, 8'hFF, 8'hFF, 8'h00, 1'b0)};
        directed = {directed, make_pixel(1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b1)};
        foreach (directed[i]) begin
            send_pixel(directed[i]);
        end

        // Random phases, each with its own centres and idling pattern.
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            load_centres(phase);
            case (phase)
                0: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                1: begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 67;
                end
                default: begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 30;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                send_image(sent);
                phase_sent += sent;
            end
        end

        settle();
        if (stream_book.failures == 0 && stream_book.expected_bytes.size() == 0) begin
            $display("cluster_delta_run_encoder_test passed");
        end else begin
            $display("cluster_delta_run_encoder_test failed");
        end
        $finish;
    end

endmodule
